[sv/gri_pkg.sv]
// Shared types and constants for the gyro rate heading integrator.
package gri_pkg;

  localparam int unsigned AccW  = 64;
  localparam int unsigned CntW  = 32;
  localparam int unsigned HdgW  = 41;
  localparam int unsigned CtrW  = 16;
  localparam int unsigned GainW = 48;
  localparam int unsigned DvdW  = 80;
  localparam int unsigned DvsW  = 33;
  localparam int unsigned MulW  = 48;
  localparam int unsigned McW   = 64;
  localparam int unsigned PrdW  = McW + MulW;
  localparam int unsigned IterW = 7;

  localparam logic [IterW-1:0] DivLast = IterW'(DvdW - 1);
  localparam logic [IterW-1:0] MulLast = IterW'(MulW - 1);

  localparam logic [2:0] CfgCenterInit = 3'd0;
  localparam logic [2:0] CfgNoiseLimit = 3'd1;
  localparam logic [2:0] CfgCwGain     = 3'd2;
  localparam logic [2:0] CfgCcwGain    = 3'd3;
  localparam logic [2:0] CfgCwSpin     = 3'd4;
  localparam logic [2:0] CfgCcwSpin    = 3'd5;

  localparam logic [31:0] CenterRst   = 32'h8000_0000;
  localparam logic [31:0] NoiseRst    = 32'h0001_0000;
  localparam logic [40:0] MeanLim     = 41'h100_0000_0000;
  localparam logic [42:0] Deg180      = 43'd773094113280;
  localparam logic [42:0] Deg360      = 43'd1546188226560;
  localparam logic [13:0] CenterScale = 14'd10000;

  typedef struct packed {
    logic cap;
    logic div_init_mean;
    logic div_init_ctr;
    logic div_step;
    logic mean_done;
    logic ctr_done;
    logic mul_init_lin;
    logic lin_done;
    logic sq_done;
    logic mul_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic is_zero;
    logic is_stale;
    logic calib;
  } sts_t;

endpackage

[sv/gri_datapath.sv]
// Datapath: state, serial divider, serial multiplier, result register.
module gri_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gri_pkg::cmd_t  cmd_i,
  output gri_pkg::sts_t  sts_o,
  input  logic           req_type_i,
  input  logic [63:0]    accum_total_i,
  input  logic [31:0]    count_total_i,
  input  logic [31:0]    elapsed_us_i,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_index_i,
  input  logic [47:0]    cfg_data_i,
  output logic [151:0]   out_data_o
);

  // configuration
  logic [31:0] noise_limit_q;
  logic [47:0] cw_gain_q, ccw_gain_q, cw_spin_q, ccw_spin_q;

  // architectural state
  logic [63:0] prev_accum_q;
  logic [31:0] prev_count_q;
  logic [31:0] center_q;
  logic        calib_q;
  logic [40:0] last_inc_q;
  logic [40:0] heading_q;
  logic [15:0] noisy_q;
  logic [15:0] stale_q;

  // per-item
  logic        zero_q;
  logic [63:0] accum_in_q;
  logic [31:0] count_in_q;
  logic [31:0] elapsed_q;
  logic [63:0] dacc_q;
  logic [31:0] dcnt_q;
  logic [42:0] dev_q;
  logic [41:0] devmag_q;
  logic        noisy_hit_q;
  logic [47:0] lin_q;

  // serial units
  logic [79:0] dvd_q;
  logic [32:0] rem_q;
  logic [32:0] dvs_q;
  logic [63:0] mcand_q;
  logic [47:0] mplier_q;
  logic [111:0] prod_q;

  logic [151:0] out_q;

  // divider step
  logic [33:0] div_t;
  logic        div_ge;
  always_comb begin
    div_t  = {rem_q, dvd_q[79]};
    div_ge = div_t >= {1'b0, dvs_q};
  end

  // multiplier step
  logic [64:0] mul_sum;
  assign mul_sum = {1'b0, prod_q[111:48]} + {1'b0, (mplier_q[0] ? mcand_q : 64'd0)};

  // mean and deviation
  logic [63:0] dacc_mag;
  logic [40:0] mean_mag;
  logic [42:0] mean_s, dev_n;
  logic [41:0] devmag_n;
  always_comb begin
    dacc_mag = dacc_q[63] ? (~dacc_q + 64'd1) : dacc_q;
    mean_mag = (dvd_q > {39'd0, gri_pkg::MeanLim}) ? gri_pkg::MeanLim : dvd_q[40:0];
    mean_s   = dacc_q[63] ? (43'd0 - {2'b0, mean_mag}) : {2'b0, mean_mag};
    dev_n    = mean_s - {11'd0, center_q};
    devmag_n = dev_n[42] ? 42'(43'd0 - dev_n) : dev_n[41:0];
  end

  // center update
  logic [55:0] ctr_num;
  logic [44:0] ctr_delta, ctr_nc;
  logic [31:0] ctr_new;
  always_comb begin
    ctr_num   = {14'd0, devmag_q} * {42'd0, gri_pkg::CenterScale};
    ctr_delta = dev_q[42] ? (45'd0 - {2'b0, dvd_q[42:0]}) : {2'b0, dvd_q[42:0]};
    ctr_nc    = {13'd0, center_q} + ctr_delta;
    if (ctr_nc[44])                ctr_new = 32'd0;
    else if (ctr_nc[43:32] != '0)  ctr_new = 32'hFFFF_FFFF;
    else                           ctr_new = ctr_nc[31:0];
  end

  // rate terms
  logic        d_pos, d_neg, coef_neg;
  logic [31:0] dmag;
  logic [47:0] gain_sel, coef_sel, coef_mag;
  logic [50:0] quad;
  logic [53:0] lin_s, quad_s, rsum;
  logic [40:0] inc_fresh;
  always_comb begin
    d_neg    = dev_q[42];
    d_pos    = !dev_q[42] && (dev_q != '0);
    dmag     = (devmag_q > 42'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : devmag_q[31:0];
    gain_sel = d_pos ? cw_gain_q : ccw_gain_q;
    coef_sel = d_pos ? cw_spin_q : ccw_spin_q;
    coef_neg = coef_sel[47];
    coef_mag = coef_neg ? (48'd0 - coef_sel) : coef_sel;
    quad     = prod_q[110:60];
    lin_s    = d_neg ? (54'd0 - {6'd0, lin_q}) : {6'd0, lin_q};
    quad_s   = coef_neg ? (54'd0 - {3'd0, quad}) : {3'd0, quad};
    rsum     = lin_s + quad_s;
    if (!rsum[53] && rsum > {11'd0, gri_pkg::Deg180})
      inc_fresh = gri_pkg::Deg180[40:0];
    else if (rsum[53] && rsum < (54'd0 - {11'd0, gri_pkg::Deg180}))
      inc_fresh = 41'd0 - gri_pkg::Deg180[40:0];
    else
      inc_fresh = rsum[40:0];
  end

  // heading and counters at commit
  logic [40:0] inc_sel;
  logic [42:0] hsum;
  logic [40:0] hnew;
  logic [15:0] stale_n, noisy_n;
  always_comb begin
    if (zero_q)        inc_sel = '0;
    else if (dcnt_q == '0) inc_sel = last_inc_q;
    else               inc_sel = inc_fresh;
    hsum = {2'b0, heading_q} + {{2{inc_sel[40]}}, inc_sel};
    if (!hsum[42] && hsum > gri_pkg::Deg360) hnew = 41'(hsum - gri_pkg::Deg360);
    else if (hsum[42])                       hnew = 41'(hsum + gri_pkg::Deg360);
    else                                     hnew = hsum[40:0];
    stale_n = (stale_q == '1) ? stale_q : stale_q + 16'd1;
    noisy_n = (noisy_hit_q && calib_q && noisy_q != '1) ? noisy_q + 16'd1 : noisy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_limit_q <= gri_pkg::NoiseRst;
      cw_gain_q     <= '0;
      ccw_gain_q    <= '0;
      cw_spin_q     <= '0;
      ccw_spin_q    <= '0;
      prev_accum_q  <= '0;
      prev_count_q  <= '0;
      center_q      <= gri_pkg::CenterRst;
      calib_q       <= 1'b1;
      last_inc_q    <= '0;
      heading_q     <= '0;
      noisy_q       <= '0;
      stale_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          gri_pkg::CfgCenterInit: center_q      <= cfg_data_i[31:0];
          gri_pkg::CfgNoiseLimit: noise_limit_q <= cfg_data_i[31:0];
          gri_pkg::CfgCwGain:     cw_gain_q     <= cfg_data_i;
          gri_pkg::CfgCcwGain:    ccw_gain_q    <= cfg_data_i;
          gri_pkg::CfgCwSpin:     cw_spin_q     <= cfg_data_i;
          gri_pkg::CfgCcwSpin:    ccw_spin_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.ctr_done) center_q <= ctr_new;
      if (cmd_i.commit) begin
        if (zero_q) begin
          if (calib_q) begin
            calib_q   <= 1'b0;
            heading_q <= '0;
          end
        end else if (dcnt_q == '0) begin
          stale_q   <= stale_n;
          heading_q <= hnew;
        end else begin
          noisy_q      <= noisy_n;
          last_inc_q   <= inc_fresh;
          prev_count_q <= count_in_q;
          prev_accum_q <= accum_in_q;
          heading_q    <= hnew;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      zero_q     <= req_type_i;
      accum_in_q <= accum_total_i;
      count_in_q <= count_total_i;
      elapsed_q  <= elapsed_us_i;
      dacc_q     <= accum_total_i - prev_accum_q;
      dcnt_q     <= count_total_i - prev_count_q;
    end
    if (cmd_i.div_init_mean) begin
      dvd_q <= {dacc_mag, 16'd0};
      rem_q <= '0;
      dvs_q <= {1'b0, dcnt_q};
    end
    if (cmd_i.div_init_ctr) begin
      dvd_q <= {24'd0, ctr_num};
      rem_q <= '0;
      dvs_q <= {1'b0, elapsed_q} + {19'd0, gri_pkg::CenterScale};
    end
    if (cmd_i.div_step) begin
      rem_q <= div_ge ? 33'(div_t - {1'b0, dvs_q}) : div_t[32:0];
      dvd_q <= {dvd_q[78:0], div_ge};
    end
    if (cmd_i.mean_done) begin
      dev_q       <= dev_n;
      devmag_q    <= devmag_n;
      noisy_hit_q <= devmag_n > {10'd0, noise_limit_q};
    end
    if (cmd_i.mul_init_lin) begin
      mcand_q  <= {32'd0, dmag};
      mplier_q <= gain_sel;
      prod_q   <= '0;
    end
    if (cmd_i.lin_done) begin
      lin_q    <= prod_q[79:32];
      mcand_q  <= {32'd0, dmag};
      mplier_q <= {16'd0, dmag};
      prod_q   <= '0;
    end
    if (cmd_i.sq_done) begin
      mcand_q  <= prod_q[63:0];
      mplier_q <= coef_mag;
      prod_q   <= '0;
    end
    if (cmd_i.mul_step) begin
      prod_q   <= {mul_sum, prod_q[47:1]};
      mplier_q <= {1'b0, mplier_q[47:1]};
    end
    if (cmd_i.commit) begin
      out_q <= {4'd0,
                (!zero_q && dcnt_q == '0) ? stale_n : stale_q,
                (zero_q || dcnt_q == '0) ? noisy_q : noisy_n,
                !zero_q && dcnt_q != '0,
                calib_q && !zero_q,
                (!zero_q && dcnt_q != '0 && calib_q) ? center_q : center_q,
                inc_sel,
                zero_q ? (calib_q ? 41'd0 : heading_q) : hnew};
    end
  end

  assign sts_o.is_zero  = zero_q;
  assign sts_o.is_stale = (dcnt_q == '0);
  assign sts_o.calib    = calib_q;
  assign out_data_o     = out_q;

endmodule

[sv/gri_ctrl.sv]
// Controller: sequences capture, divisions, multiplications and commit.
module gri_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  gri_pkg::sts_t sts_i,
  output gri_pkg::cmd_t cmd_o
);

  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StClass   = 4'd1;
  localparam logic [3:0] StDivMean = 4'd2;
  localparam logic [3:0] StMean    = 4'd3;
  localparam logic [3:0] StCtrInit = 4'd4;
  localparam logic [3:0] StDivCtr  = 4'd5;
  localparam logic [3:0] StCtrDone = 4'd6;
  localparam logic [3:0] StLinInit = 4'd7;
  localparam logic [3:0] StMulLin  = 4'd8;
  localparam logic [3:0] StMulSq   = 4'd9;
  localparam logic [3:0] StMulQuad = 4'd10;
  localparam logic [3:0] StSqDone  = 4'd11;
  localparam logic [3:0] StFinish  = 4'd12;

  logic [3:0] state_q, state_d;
  logic [gri_pkg::IterW-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q + 1'b1;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = StClass;
        end
      end
      StClass: begin
        cnt_d = '0;
        if (sts_i.is_zero || sts_i.is_stale) begin
          state_d = StFinish;
        end else begin
          cmd_o.div_init_mean = 1'b1;
          state_d             = StDivMean;
        end
      end
      StDivMean: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == gri_pkg::DivLast) state_d = StMean;
      end
      StMean: begin
        cmd_o.mean_done = 1'b1;
        state_d         = sts_i.calib ? StCtrInit : StLinInit;
      end
      StCtrInit: begin
        cmd_o.div_init_ctr = 1'b1;
        cnt_d              = '0;
        state_d            = StDivCtr;
      end
      StDivCtr: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == gri_pkg::DivLast) state_d = StCtrDone;
      end
      StCtrDone: begin
        cmd_o.ctr_done = 1'b1;
        state_d        = StLinInit;
      end
      StLinInit: begin
        cmd_o.mul_init_lin = 1'b1;
        cnt_d              = '0;
        state_d            = StMulLin;
      end
      StMulLin: begin
        cmd_o.mul_step = 1'b1;
        if (cnt_q == gri_pkg::MulLast) begin
          state_d = StMulSq;
        end
      end
      StMulSq: begin
        // first cycle here loads the square operands
        if (cnt_q == gri_pkg::IterW'(gri_pkg::MulW)) begin
          cmd_o.lin_done = 1'b1;
          cnt_d          = '0;
        end else begin
          cmd_o.mul_step = 1'b1;
          if (cnt_q == gri_pkg::MulLast) state_d = StSqDone;
        end
      end
      StSqDone: begin
        cmd_o.sq_done = 1'b1;
        cnt_d         = '0;
        state_d       = StMulQuad;
      end
      StMulQuad: begin
        cmd_o.mul_step = 1'b1;
        if (cnt_q == gri_pkg::MulLast) state_d = StFinish;
      end
      StFinish: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[sv/gyro_rate_heading_integrator.sv]
// Top level of the gyro rate heading integrator.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/tready          tuser: req_type; tdata: accum, count, elapsed
//  m_axis    out  m_axis_tvalid/tready          tdata: heading .. no_data_count
//  cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// A fresh sample runs two 80-step restoring divisions (mean, center correction;
// the second only while calibrating) and three 48-step shift-add
// multiplications on one shared multiplier. Zero requests and samples without
// new readings skip the divisions and multiplications.
// Reset clears the architectural state and configuration, not the per-item
// and result registers; the result register holds until taken and
// a new request is taken while a result still waits.
module gyro_rate_heading_integrator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [127:0]  s_axis_tdata_i,   // accum_total[63:0], count_total, elapsed_us
  input  logic [0:0]    s_axis_tuser_i,   // req_type
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [151:0]  m_axis_tdata_o,   // heading, rate_increment, center_now, calibrating,
                                          // data_fresh, noisy_count, no_data_count, pad
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [47:0]   cfg_data_i
);

  gri_pkg::cmd_t cmd;
  gri_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  gri_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gri_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_type_i    (s_axis_tuser_i[0]),
    .accum_total_i (s_axis_tdata_i[63:0]),
    .count_total_i (s_axis_tdata_i[95:64]),
    .elapsed_us_i  (s_axis_tdata_i[127:96]),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_data_o    (m_axis_tdata_o)
  );

endmodule

[dv/gri_checker.sv]
// Heading integrator checker: predicts each result and compares it on the output stream.
module gri_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [127:0] s_tdata_i,
  input  logic [0:0]   s_tuser_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [151:0] m_tdata_i,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [47:0]  cfg_data_i,
  output int           fail_count_o,
  output int           pending_o,
  output int           results_o
);

  localparam longint Deg180L = 64'd773094113280;
  localparam longint Deg360L = 64'd1546188226560;
  localparam longint MeanLimL = 64'd1099511627776;
  localparam longint Max32L = 64'hFFFF_FFFF;

  // packed from the top bit down, so heading sits in the lowest bits
  typedef struct packed {
    logic [15:0] stale;
    logic [15:0] noisy;
    logic        fresh;
    logic        calib;
    logic [31:0] center;
    logic [40:0] rate_inc;
    logic [40:0] heading;
  } heading_res_t;

  heading_res_t heading_exp_q[$];

  // configuration copy
  logic [31:0] center_init_r, noise_limit_r;
  logic [47:0] cw_gain_r, ccw_gain_r, cw_spin_r, ccw_spin_r;
  // integrator state
  logic [63:0] last_accum;
  logic [31:0] last_count, center_r;
  logic        calib_r;
  longint      last_inc, heading_r;
  logic [15:0] noisy_r, stale_r;
  int          mismatches;

  function automatic logic [15:0] bump(logic [15:0] c);
    return (c == 16'hFFFF) ? c : c + 16'd1;
  endfunction

  // degrees for one deviation: linear gain plus quadratic spin term, saturated
  function automatic longint rate_of_dev(longint dev);
    longint d, lin, quad, sum;
    logic [31:0] mag;
    logic [47:0] gain, coef, cmag;
    logic [127:0] prod;
    d = dev;
    if (d > Max32L) d = Max32L;
    if (d < -Max32L) d = -Max32L;
    mag  = (d < 0) ? 32'(-d) : 32'(d);
    gain = (d > 0) ? cw_gain_r : ccw_gain_r;
    coef = (d > 0) ? cw_spin_r : ccw_spin_r;
    cmag = coef[47] ? 48'h0 - coef : coef;
    prod = 128'(mag) * 128'(gain);
    lin  = longint'(prod >> 32);
    if (d < 0) lin = -lin;
    prod = 128'(64'(mag) * 64'(mag)) * 128'(cmag);
    quad = longint'(prod >> 60);
    if (coef[47]) quad = -quad;
    sum = lin + quad;
    if (sum > Deg180L) sum = Deg180L;
    if (sum < -Deg180L) sum = -Deg180L;
    return sum;
  endfunction

  function automatic heading_res_t integrate(logic is_zero, logic [127:0] d);
    heading_res_t res;
    logic [63:0] acc;
    logic [31:0] cnt, el, dcount;
    longint inc, daccum, dc, q, r, mean, dev, nc;
    logic [63:0] amag;
    logic fresh;
    acc = d[63:0];
    cnt = d[95:64];
    el  = d[127:96];
    inc = 0;
    fresh = 1'b0;
    if (is_zero) begin
      if (calib_r) begin
        calib_r = 1'b0;
        heading_r = 0;
      end
    end else begin
      dcount = cnt - last_count;
      if (dcount == 0) begin
        stale_r = bump(stale_r);
        inc = last_inc;
      end else begin
        daccum = signed'(acc - last_accum);
        dc = longint'({32'b0, dcount});
        q = daccum / dc;
        r = daccum % dc;
        fresh = 1'b1;
        if (q > (64'sd1 <<< 24)) mean = MeanLimL;
        else if (q < -(64'sd1 <<< 24)) mean = -MeanLimL;
        else begin
          mean = q * 65536 + (r * 65536) / dc;
          if (mean > MeanLimL) mean = MeanLimL;
          if (mean < -MeanLimL) mean = -MeanLimL;
        end
        dev = mean - longint'({32'b0, center_r});
        if (calib_r) begin
          amag = (dev < 0) ? 64'(-dev) : 64'(dev);
          if (amag > 64'(noise_limit_r)) noisy_r = bump(noisy_r);
          nc = longint'({32'b0, center_r}) + (dev * 10000) / (longint'({32'b0, el}) + 10000);
          if (nc < 0) nc = 0;
          if (nc > Max32L) nc = Max32L;
          center_r = 32'(nc);
        end
        inc = rate_of_dev(dev);
        last_inc = inc;
        last_count = cnt;
        last_accum = acc;
      end
      heading_r = heading_r + inc;
      if (heading_r > Deg360L) heading_r = heading_r - Deg360L;
      else if (heading_r < 0) heading_r = heading_r + Deg360L;
    end
    res.heading  = 41'(heading_r);
    res.rate_inc = 41'(inc);
    res.center   = center_r;
    res.calib    = calib_r;
    res.fresh    = fresh;
    res.noisy    = noisy_r;
    res.stale    = stale_r;
    return res;
  endfunction

  task automatic check_field(string nm, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h got %h (result %0d)", nm, e, a, results_o);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    heading_res_t got, exp_r;
    if (!rst_ni) begin
      center_init_r = gri_pkg::CenterRst;
      noise_limit_r = gri_pkg::NoiseRst;
      cw_gain_r = '0; ccw_gain_r = '0; cw_spin_r = '0; ccw_spin_r = '0;
      last_accum = '0; last_count = '0; center_r = gri_pkg::CenterRst; calib_r = 1'b1;
      last_inc = 0; heading_r = 0; noisy_r = '0; stale_r = '0;
      heading_exp_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      results_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          gri_pkg::CfgCenterInit: begin
            center_init_r = cfg_data_i[31:0];
            center_r = cfg_data_i[31:0];
          end
          gri_pkg::CfgNoiseLimit: noise_limit_r = cfg_data_i[31:0];
          gri_pkg::CfgCwGain:     cw_gain_r = cfg_data_i;
          gri_pkg::CfgCcwGain:    ccw_gain_r = cfg_data_i;
          gri_pkg::CfgCwSpin:     cw_spin_r = cfg_data_i;
          gri_pkg::CfgCcwSpin:    ccw_spin_r = cfg_data_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i)
        heading_exp_q.push_back(integrate(s_tuser_i[0], s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[147:0];
        if (heading_exp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result with nothing expected: %h", got);
        end else begin
          exp_r = heading_exp_q.pop_front();
          check_field("heading", 64'(exp_r.heading), 64'(got.heading));
          check_field("rate_increment", 64'(exp_r.rate_inc), 64'(got.rate_inc));
          check_field("center_now", 64'(exp_r.center), 64'(got.center));
          check_field("calibrating", 64'(exp_r.calib), 64'(got.calib));
          check_field("data_fresh", 64'(exp_r.fresh), 64'(got.fresh));
          check_field("noisy_count", 64'(exp_r.noisy), 64'(got.noisy));
          check_field("no_data_count", 64'(exp_r.stale), 64'(got.stale));
        end
        results_o <= results_o + 1;
      end
      fail_count_o <= mismatches;
      pending_o <= heading_exp_q.size();
    end
  end

endmodule

[dv/gyro_rate_heading_integrator_tb.sv]
// Testbench top: stimulus, stall control and verdict for the heading integrator.
module gyro_rate_heading_integrator_tb;

  // watchdog: cycles without any request, result or cfg write moving
  localparam int IdleLimit = 20000;
  localparam int HoldCycles = 2500;
  // index past the register list
  localparam logic [2:0] CfgNoReg = 3'd6;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;   // accum_total, count_total, elapsed_us
  logic [0:0]   s_tuser = '0;   // req_type
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [151:0] m_tdata;        // heading .. no_data_count, pad
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [47:0]  cfg_data = '0;

  int fail_count, pending, results;

  // stall knobs, in percent
  int tx_gap_pct, rx_stall_pct;
  bit hold_off;
  int idle_cycles;

  // sensor model for well-formed sample streams
  logic [63:0] sens_acc;
  logic [31:0] sens_cnt, sens_time, center_raw;
  int sent_items, zero_items, stale_items, cfg_writes;

  gyro_rate_heading_integrator i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  gri_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !hold_off && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no traffic for %0d cycles, %0d results pending", IdleLimit, pending);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // idle profile follows progress: receiver-heavy stalls, then sender-heavy gaps, then none
  task automatic set_idling();
    if (sent_items < 420) begin
      tx_gap_pct = 16; rx_stall_pct = 60;
    end else if (sent_items < 840) begin
      tx_gap_pct = 60; rx_stall_pct = 16;
    end else begin
      tx_gap_pct = 0; rx_stall_pct = 0;
    end
  endtask

  // one request; valid drops only during a gap, so no double drive in a step
  task automatic send_item(logic kind, logic [63:0] acc, logic [31:0] cnt, logic [31:0] el);
    set_idling();
    while ($urandom_range(99) < tx_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {el, cnt, acc};
    do @(posedge clk_i); while (!s_tready);
    sent_items++;
    if (kind) zero_items++;
  endtask

  // stop offering and wait for every expected result
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
    cfg_writes++;
    if (idx == gri_pkg::CfgCenterInit) center_raw = {16'b0, val[31:16]};
  endtask

  task automatic cfg_all(logic [31:0] ctr, logic [31:0] noise, logic [47:0] cwg,
                         logic [47:0] ccwg, logic [47:0] cws, logic [47:0] ccws);
    cfg_write(gri_pkg::CfgCenterInit, {16'b0, ctr});
    cfg_write(gri_pkg::CfgNoiseLimit, {16'b0, noise});
    cfg_write(gri_pkg::CfgCwGain, cwg);
    cfg_write(gri_pkg::CfgCcwGain, ccwg);
    cfg_write(gri_pkg::CfgCwSpin, cws);
    cfg_write(gri_pkg::CfgCcwSpin, ccws);
  endtask

  function automatic logic [47:0] rand48();
    logic [47:0] v;
    v = 48'({$urandom, $urandom});
    return v >> $urandom_range(47);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly well-formed sensor totals, with stale, backward, noise and zero requests
  task automatic random_item(bit zeros_ok);
    int pick, n, amp;
    longint raw;
    pick = $urandom_range(99);
    sens_time = ($urandom_range(19) == 0) ? $urandom : sens_time + 100;
    if (pick < 70) begin
      n = $urandom_range(1, 40);
      amp = 1 << (4 * $urandom_range(0, 3) + 2);
      raw = longint'(center_raw) + $urandom_range(0, 2 * amp) - amp;
      sens_acc = sens_acc + 64'(n * raw);
      sens_cnt = sens_cnt + n;
      send_item(1'b0, sens_acc, sens_cnt, sens_time);
    end else if (pick < 80) begin
      stale_items++;
      send_item(1'b0, rand64(), sens_cnt, sens_time);
    end else if (pick < 85) begin
      sens_cnt = sens_cnt - $urandom_range(1, 1000);
      sens_acc = sens_acc - 64'($urandom);
      send_item(1'b0, sens_acc, sens_cnt, sens_time);
    end else if (pick < 97 || !zeros_ok) begin
      sens_acc = rand64();
      sens_cnt = $urandom;
      send_item(1'b0, sens_acc, sens_cnt, $urandom);
    end else begin
      send_item(1'b1, rand64(), $urandom, $urandom);
    end
  endtask

  task automatic random_run(int count, bit zeros_ok);
    for (int k = 0; k < count; k++) random_item(zeros_ok);
  endtask

  initial begin
    hold_off = 1'b0;
    idle_cycles = 0;
    sent_items = 0; zero_items = 0; stale_items = 0; cfg_writes = 0;
    center_raw = 32'd32768;
    tx_gap_pct = 16; rx_stall_pct = 60;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // moderate gains, opposite spin signs; an unknown index must be ignored
    cfg_all(32'h8000_0000, 32'h0001_0000, 48'h10_0000_0000, 48'h18_0000_0000,
            48'h10_0000, 48'hFFFF_FFF0_0000);
    cfg_write(CfgNoReg, 48'hFFFF_FFFF_FFFF);

    // directed: stale first sample, steady, both turn directions, stale repeat
    send_item(1'b0, 64'd0, 32'd0, 32'd0);
    send_item(1'b0, 64'd327680, 32'd10, 32'd0);
    send_item(1'b0, 64'd327680 + 64'd328000, 32'd20, 32'hFFFF_FFFF);
    send_item(1'b0, 64'd982680, 32'd30, 32'd200);
    send_item(1'b0, 64'd982680, 32'd30, 32'd300);
    // positive mean saturation, wrapped accumulator delta
    send_item(1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 32'd31, 32'd400);
    send_item(1'b0, 64'h8000_0000_0000_0000, 32'd32, 32'd500);
    // count going backward, then the widest count delta
    send_item(1'b0, 64'd0, 32'd5, 32'd600);
    send_item(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd4, 32'd700);
    send_item(1'b0, 64'd4 * 64'd32768 + 64'hFFFF_FFFF_FFFF_FFFF, 32'd8, 32'd800);
    sens_acc = 64'd4 * 64'd32768 + 64'hFFFF_FFFF_FFFF_FFFF;
    sens_cnt = 32'd8;
    sens_time = 32'd800;

    // long receiver hold-off while requests keep coming: input must back up
    fork
      begin
        hold_off = 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join_none
    random_run(280, 1'b0);
    drain();

    // all-ones extremes, most negative ccw spin
    cfg_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
            48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
    random_run(200, 1'b0);
    drain();

    // zero extremes; calibration ends here, second zero request is a no-op
    cfg_all(32'h0, 32'h0, 48'h0, 48'h0, 48'h0, 48'h0);
    send_item(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(1'b0, sens_acc, sens_cnt, sens_time);
    send_item(1'b1, 64'd0, 32'd0, 32'd0);
    send_item(1'b0, sens_acc + 64'd100, sens_cnt + 32'd3, sens_time);
    sens_acc = sens_acc + 64'd100;
    sens_cnt = sens_cnt + 32'd3;
    random_run(200, 1'b1);
    drain();

    // random settings for the rest
    for (int ph = 0; ph < 4; ph++) begin
      cfg_all($urandom, $urandom >> $urandom_range(31), rand48(), rand48(),
              rand48(), rand48());
      random_run(145, 1'b1);
      drain();
    end

    repeat (300) @(posedge clk_i);
    $display("covered %0d requests (%0d zero, %0d stale-count), %0d results, %0d cfg writes",
             sent_items, zero_items, stale_items, results, cfg_writes);
    $display("settings: default-like, all-ones, all-zero and random; three stall profiles");
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
sv/gri_pkg.sv
sv/gri_datapath.sv
sv/gri_ctrl.sv
sv/gyro_rate_heading_integrator.sv
dv/gri_checker.sv
dv/gyro_rate_heading_integrator_tb.sv
